### hdl/lcm_pkg.sv
// ----------------------------------------------------------------------------
// lcm_pkg: shared types and constants for the lcm unit
// word width, sequencer states and the request format of the shared adder
// ----------------------------------------------------------------------------
package lcm_pkg;

    localparam int WORD_W = 32;
    // shared adder operands carry one guard bit; the result adds a sign bit
    localparam int ALU_W  = WORD_W + 1;
    localparam int CNT_W  = $clog2(WORD_W);

    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(WORD_W - 1);

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_COMMON = 6'b000010,
        ST_ODDU   = 6'b000100,
        ST_REDUCE = 6'b001000,
        ST_DIVIDE = 6'b010000,
        ST_MULT   = 6'b100000
    } state_t;

    typedef struct packed {
        logic [ALU_W-1:0] op_a;
        logic [ALU_W-1:0] op_b;
        logic             sub;
    } alu_req_t;

endpackage

### hdl/lcm_unit.sv
// ----------------------------------------------------------------------------
// lcm_unit: least common multiple of two 32-bit unsigned operands
// binary gcd, restoring division of the first operand by the gcd and a
// shift-add multiply by the second operand, all on one shared adder
// ----------------------------------------------------------------------------
// a zero operand gives its result in the next cycle; otherwise the work runs
//   through the shared-factor and odd-making halvings (31 at most), the
//   subtract/halve gcd loop, then 32 divide and 32 multiply steps
// one transfer at a time; busy drops with the done strobe, so the next
//   transfer is taken only once the previous result is out
// done marks multiple/overflowed for one cycle, no stall; reset: async, to idle
// ----------------------------------------------------------------------------
module lcm_unit
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [lcm_pkg::WORD_W-1:0]   first_operand,
    input  logic [lcm_pkg::WORD_W-1:0]   second_operand,
    output logic                         done,
    output logic [lcm_pkg::WORD_W-1:0]   multiple,
    output logic                         overflowed
);

    // sequencer state
    lcm_pkg::state_t state_reg, state_next;

    // u/v: binary gcd pair; a: dividend, then quotient, then product low half
    logic [lcm_pkg::WORD_W-1:0] u_reg, u_next;
    logic [lcm_pkg::WORD_W-1:0] v_reg, v_next;
    logic [lcm_pkg::WORD_W-1:0] a_reg, a_next;
    // multiplicand, the untouched second operand
    logic [lcm_pkg::WORD_W-1:0] b_reg, b_next;
    // partial remainder while dividing, product high half while multiplying
    logic [lcm_pkg::WORD_W-1:0] acc_reg, acc_next;
    logic [lcm_pkg::CNT_W-1:0]  cnt_reg, cnt_next;

    // result registers
    logic                       done_reg, done_next;
    logic [lcm_pkg::WORD_W-1:0] mult_reg, mult_next;
    logic                       ovf_reg, ovf_next;

    // shared adder
    lcm_pkg::alu_req_t          alu_req;
    logic [lcm_pkg::ALU_W:0]    alu_sum;

    // divider: partial remainder with the next dividend bit shifted in
    logic [lcm_pkg::ALU_W-1:0]  div_shift;

    logic accept;

    assign accept    = start && !busy;
    assign busy      = (state_reg != lcm_pkg::ST_IDLE);
    assign div_shift = {acc_reg, a_reg[lcm_pkg::WORD_W-1]};

    lcm_alu u_alu
    (
        .req (alu_req),
        .sum (alu_sum)
    );

    always_comb
    begin
        state_next = state_reg;
        u_next     = u_reg;
        v_next     = v_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        acc_next   = acc_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        mult_next  = mult_reg;
        ovf_next   = ovf_reg;

        alu_req      = '0;

        unique case (state_reg)
            lcm_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    if ((first_operand == '0) || (second_operand == '0))
                    begin
                        // zero operand: answer at once
                        mult_next = '0;
                        ovf_next  = 1'b0;
                        done_next = 1'b1;
                    end
                    else
                    begin
                        u_next     = first_operand;
                        v_next     = second_operand;
                        a_next     = first_operand;
                        b_next     = second_operand;
                        state_next = lcm_pkg::ST_COMMON;
                    end
                end
            end

            lcm_pkg::ST_COMMON:
            begin
                // strip shared factors of two; the dividend loses them too,
                // so dividing it by the odd part of the gcd gives first / gcd
                if (u_reg[0] || v_reg[0])
                begin
                    state_next = lcm_pkg::ST_ODDU;
                end
                else
                begin
                    u_next = u_reg >> 1;
                    v_next = v_reg >> 1;
                    a_next = a_reg >> 1;
                end
            end

            lcm_pkg::ST_ODDU:
            begin
                if (u_reg[0])
                begin
                    state_next = lcm_pkg::ST_REDUCE;
                end
                else
                begin
                    u_next = u_reg >> 1;
                end
            end

            lcm_pkg::ST_REDUCE:
            begin
                // u stays odd; v - u of two odds is even, so halve it at once
                alu_req.op_a = {1'b0, v_reg};
                alu_req.op_b = {1'b0, u_reg};
                alu_req.sub  = 1'b1;
                if (v_reg == '0)
                begin
                    acc_next   = '0;
                    cnt_next   = '0;
                    state_next = lcm_pkg::ST_DIVIDE;
                end
                else if (!v_reg[0])
                begin
                    v_next = v_reg >> 1;
                end
                else if (alu_sum[lcm_pkg::ALU_W])
                begin
                    // v below u: swap, subtract on the next cycle
                    u_next = v_reg;
                    v_next = u_reg;
                end
                else
                begin
                    v_next = alu_sum[lcm_pkg::WORD_W:1];
                end
            end

            lcm_pkg::ST_DIVIDE:
            begin
                // restoring division, one quotient bit a step
                alu_req.op_a = div_shift;
                alu_req.op_b = {1'b0, u_reg};
                alu_req.sub  = 1'b1;
                if (!alu_sum[lcm_pkg::ALU_W])
                begin
                    acc_next = alu_sum[lcm_pkg::WORD_W-1:0];
                    a_next   = {a_reg[lcm_pkg::WORD_W-2:0], 1'b1};
                end
                else
                begin
                    acc_next = div_shift[lcm_pkg::WORD_W-1:0];
                    a_next   = {a_reg[lcm_pkg::WORD_W-2:0], 1'b0};
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == lcm_pkg::LAST_STEP)
                begin
                    acc_next   = '0;
                    cnt_next   = '0;
                    state_next = lcm_pkg::ST_MULT;
                end
            end

            lcm_pkg::ST_MULT:
            begin
                // shift-add: quotient in a is the multiplier, acc the high half
                alu_req.op_a = {1'b0, acc_reg};
                alu_req.op_b = a_reg[0] ? {1'b0, b_reg} : '0;
                alu_req.sub  = 1'b0;
                acc_next = alu_sum[lcm_pkg::WORD_W:1];
                a_next   = {alu_sum[0], a_reg[lcm_pkg::WORD_W-1:1]};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == lcm_pkg::LAST_STEP)
                begin
                    mult_next  = {alu_sum[0], a_reg[lcm_pkg::WORD_W-1:1]};
                    ovf_next   = |alu_sum[lcm_pkg::WORD_W:1];
                    done_next  = 1'b1;
                    cnt_next   = '0;
                    state_next = lcm_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = lcm_pkg::ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lcm_pkg::ST_IDLE;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            cnt_reg   <= cnt_next;
        end
    end

    // datapath, no reset needed
    always_ff @(posedge clk)
    begin
        u_reg    <= u_next;
        v_reg    <= v_next;
        a_reg    <= a_next;
        b_reg    <= b_next;
        acc_reg  <= acc_next;
        mult_reg <= mult_next;
        ovf_reg  <= ovf_next;
    end

    assign done       = done_reg;
    assign multiple   = mult_reg;
    assign overflowed = ovf_reg;

    // zero operand gives an immediate zero result
    a_zero_result: assert property (@(posedge clk) disable iff (!rst_n)
        accept && ((first_operand == '0) || (second_operand == '0))
        |=> done && (multiple == '0) && !overflowed)
        else $error("zero operand did not give a zero result");

    // a nonzero transfer keeps the unit busy on the next cycle
    a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (first_operand != '0) && (second_operand != '0) |=> busy && !done)
        else $error("unit not busy after a transfer");

    // the result strobe only shows with the sequencer back in idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    // gcd reduction keeps u odd
    a_u_odd: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lcm_pkg::ST_REDUCE) |-> u_reg[0])
        else $error("gcd candidate lost oddness");

    // divisor never zero while dividing
    a_divisor_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lcm_pkg::ST_DIVIDE) |-> (u_reg != '0))
        else $error("division by zero");

endmodule

### hdl/lcm_alu.sv
// ----------------------------------------------------------------------------
// lcm_alu: shared add/subtract unit
// one adder serves the gcd reduction, the divider and the multiplier
// ----------------------------------------------------------------------------
module lcm_alu
(
    input  lcm_pkg::alu_req_t       req,
    output logic [lcm_pkg::ALU_W:0] sum
);

    logic [lcm_pkg::ALU_W:0] ext_a;
    logic [lcm_pkg::ALU_W:0] ext_b;

    assign ext_a = {1'b0, req.op_a};
    assign ext_b = {1'b0, req.op_b};

    // msb of sum is the borrow on subtract, the carry on add
    assign sum = req.sub ? (ext_a - ext_b) : (ext_a + ext_b);

endmodule

### dv/tb_lcm_unit.sv
// ----------------------------------------------------------------------------
// tb_lcm_unit: self-checking testbench for the lcm unit
// drives operand pairs through the start/busy handshake with random gaps,
// predicts each least common multiple and its wrap flag, and compares every
// done strobe against the oldest prediction in order
// ----------------------------------------------------------------------------
module tb_lcm_unit;

    localparam int W = lcm_pkg::WORD_W;

    // generous bound for ~1900 transfers plus random gaps
    localparam int CYCLE_LIMIT  = 3_000_000;
    // quiet time after the last result, longer than the worst-case latency
    localparam int DRAIN_CYCLES = 300;

    // one predicted result of the unit
    typedef struct packed {
        logic [W-1:0] multiple;
        logic         overflowed;
    } lcm_result_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         start = 1'b0;
    logic         busy;
    logic [W-1:0] first_operand = '0;
    logic [W-1:0] second_operand = '0;
    logic         done;
    logic [W-1:0] multiple;
    logic         overflowed;

    // predictions waiting for their done strobe, oldest first
    lcm_result_t pending_lcms[$];
    int          mismatches  = 0;
    int          cycle_count = 0;
    // chance in percent that the sender pauses before a transfer
    int          idle_pct    = 32;

    lcm_unit i_dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .first_operand  (first_operand),
        .second_operand (second_operand),
        .done           (done),
        .multiple       (multiple),
        .overflowed     (overflowed)
    );

    always #5 clk = ~clk;

    // watchdog on a hung handshake or a missing result
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("lcm_unit: mismatch");
            $finish;
        end
    end

    // lcm by euclid's remainder loop; the product is formed at 64 bits so that
    // both the wrapped low word and the overflow flag fall out of one value
    function automatic lcm_result_t predict_lcm(input logic [W-1:0] a, input logic [W-1:0] b);
        logic [W-1:0]   x;
        logic [W-1:0]   y;
        logic [W-1:0]   rem;
        logic [2*W-1:0] product;
        lcm_result_t    res;
        res = '0;
        // a zero operand gives zero with the flag clear
        if (a == '0 || b == '0)
            return res;
        x = a;
        y = b;
        while (y != '0)
        begin
            rem = x % y;
            x   = y;
            y   = rem;
        end
        product        = {{W{1'b0}}, a / x} * {{W{1'b0}}, b};
        res.multiple   = product[W-1:0];
        res.overflowed = (product[2*W-1:W] != '0);
        return res;
    endfunction

    // random operand spread over full words, narrow values, powers of two
    // and values near the top of the range
    function automatic logic [W-1:0] random_operand();
        logic [W-1:0] v;
        case ($urandom_range(9))
            0, 1, 2, 3: v = $urandom;
            4, 5:       v = $urandom >> $urandom_range(W-1);
            6:          v = 1 << $urandom_range(W-1);
            7:          v = ~($urandom >> $urandom_range(W-1));
            8:          v = $urandom_range(1, 1000);
            default:    v = '1 - $urandom_range(15);
        endcase
        return v;
    endfunction

    // one transfer: optional pause, then hold start until busy is low at an edge.
    // start is left high on return so back-to-back transfers never drop it
    task automatic send_pair(input logic [W-1:0] a, input logic [W-1:0] b);
        int gap;
        if ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            // mostly short pauses, now and then a long one so the next start
            // lands anywhere inside the unit's work on the previous pair
            if ($urandom_range(9) == 0)
                gap = $urandom_range(1, 250);
            else
            begin
                gap = 1;
                while ($urandom_range(99) < idle_pct)
                    gap++;
            end
            repeat (gap) @(posedge clk);
        end
        start          <= 1'b1;
        first_operand  <= a;
        second_operand <= b;
        do
            @(posedge clk);
        while (busy);
        // accepted at this edge
        pending_lcms.push_back(predict_lcm(a, b));
    endtask

    // every done strobe is matched against the oldest prediction
    always @(posedge clk)
    begin
        lcm_result_t want;
        if (rst_n && done)
        begin
            if (pending_lcms.size() == 0)
            begin
                $error("multiple: expected no result, got %08h", multiple);
                mismatches++;
            end
            else
            begin
                want = pending_lcms.pop_front();
                if (multiple !== want.multiple)
                begin
                    $error("multiple: expected %08h, got %08h", want.multiple, multiple);
                    mismatches++;
                end
                if (overflowed !== want.overflowed)
                begin
                    $error("overflowed: expected %0b, got %0b", want.overflowed, overflowed);
                    mismatches++;
                end
            end
        end
    end

    // zero on either side or both
    task automatic test_zero_operands();
        send_pair('0, '0);
        send_pair('0, '1);
        send_pair('1, '0);
        send_pair(32'd1, '0);
    endtask

    // field extremes, power-of-two gcds, overflow boundaries, slow euclid
    task automatic test_directed_pairs();
        send_pair(32'd1, 32'd1);
        send_pair(32'd1, '1);
        send_pair('1, '1);
        send_pair('1, 32'hFFFF_FFFE);              // coprime, wraps
        send_pair(32'h8000_0000, 32'h8000_0000);
        send_pair(32'h8000_0000, 32'h4000_0000);   // gcd is a large power of two
        send_pair(32'h8000_0000, 32'd3);           // wraps
        send_pair(32'h0001_0000, 32'h0001_0001);   // just over 32 bits
        send_pair(32'h0000_FFFF, 32'h0001_0001);   // exactly all ones, no wrap
        send_pair(32'h0001_0000, 32'h0001_0000);
        send_pair(32'd2971215073, 32'd1836311903); // consecutive fibonacci
        send_pair(32'd12, 32'd18);
        send_pair(32'd7, 32'd7);
        send_pair(32'hAAAA_AAAA, 32'h5555_5555);
        send_pair(32'hFFFF_FFFF, 32'h0000_0001);
    endtask

    // independent random operands, a few with a zero side
    task automatic test_random_pairs(input int count);
        logic [W-1:0] a;
        logic [W-1:0] b;
        for (int i = 0; i < count; i++)
        begin
            a = random_operand();
            b = random_operand();
            if ($urandom_range(29) == 0)
            begin
                if ($urandom_range(1))
                    a = '0;
                else
                    b = '0;
            end
            send_pair(a, b);
        end
    endtask

    // operands built around a common factor and shared powers of two, so the
    // gcd tends to be large and the common-halving and odd-making steps run long
    task automatic test_shared_factors(input int count);
        logic [W-1:0] g;
        logic [W-1:0] a;
        logic [W-1:0] b;
        int           shift;
        for (int i = 0; i < count; i++)
        begin
            g = $urandom >> $urandom_range(W-1);
            if (g == '0)
                g = 1;
            shift = $urandom_range(W-1);
            a = (g * ($urandom >> $urandom_range(W-1))) << shift;
            b = (g * ($urandom >> $urandom_range(W-1))) << $urandom_range(shift);
            send_pair(a, b);
        end
    endtask

    // a long stretch with start held high from one transfer to the next
    task automatic test_back_to_back(input int count);
        idle_pct = 0;
        test_random_pairs(count / 2);
        test_shared_factors(count - count / 2);
        idle_pct = 32;
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_zero_operands();
        test_directed_pairs();
        test_random_pairs(900);
        test_back_to_back(380);
        test_shared_factors(600);

        start <= 1'b0;
        while (pending_lcms.size() != 0)
            @(posedge clk);
        // any late or stray strobe shows up here
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (pending_lcms.size() != 0)
        begin
            $error("multiple: %0d results never arrived", pending_lcms.size());
            mismatches++;
        end

        if (mismatches == 0)
            $display("lcm_unit: match");
        else
            $display("lcm_unit: mismatch");
        $finish;
    end

endmodule
